[hdl/ipd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ipd_pkg;

	localparam int PIX_W        = 8;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 13;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int ROW_W        = 12;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int CMD_Q_DEPTH  = 4;
	localparam int OUT_Q_DEPTH  = 4;

	// 3x3 window geometry
	localparam int WIN_DIM    = 3;
	localparam int WIN_TAPS   = 9;
	localparam int WIN_CENTER = 4;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd320;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd240;

	typedef struct packed {
		logic             req_type;
		logic [PIX_W-1:0] pixel_index;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             frame_end;
	} res_t;

	typedef enum logic [1:0] {
		CMD_ROW0,
		CMD_PIXEL,
		CMD_DRAIN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      first;
		logic      last;
		logic      frame_end;
	} cmd_ctl_t;

endpackage

`default_nettype wire

[hdl/isolated_pixel_denoise_3x3.sv]
`timescale 1ns / 1ps
`default_nettype none

// 3x3 isolated-pixel removal on a raster stream of palette indices. A pixel
// whose eight neighbors share one color takes that color; borders replicate
// the nearest edge pixel. Output lags input by one row plus one pixel; after
// the last pixel of a frame, send frame_width drain requests to release the
// last row (the final result carries frame_end). Pixel requests arriving
// while a drain is pending are dropped. Requests are taken at one per clock
// sustained; ready falls only when the 4-entry command queue fills, which
// happens when the result side stalls. An accepted request passes through the
// command queue, then the registered read of the line buffer (MAX_WIDTH
// entries of two pixels, one read and one write per cycle); its results then
// leave from a 4-entry queue. The line buffer is not cleared: the first row
// of a frame fills it. Change frame_width or frame_height only while the
// block is idle.
module isolated_pixel_denoise_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire ipd_pkg::req_t                  req_data,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output ipd_pkg::res_t                       res_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CMD_W = $bits(ipd_pkg::cmd_ctl_t) + COL_W + PIXEL_BITS;

	logic                f_push;
	logic                f_space;
	ipd_pkg::cmd_ctl_t   f_ctl;
	logic [COL_W-1:0]    f_col;
	logic [PIXEL_BITS-1:0] f_pix;
	logic [CMD_W-1:0]    q_wr_data;
	logic [CMD_W-1:0]    q_rd_data;
	logic                b_valid;
	logic                b_ready;
	ipd_pkg::cmd_ctl_t   b_ctl;
	logic [COL_W-1:0]    b_col;
	logic [PIXEL_BITS-1:0] b_pix;

	ipd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cmd_push  (f_push),
		.cmd_space (f_space),
		.cmd_ctl   (f_ctl),
		.cmd_col   (f_col),
		.cmd_pix   (f_pix)
	);

	assign q_wr_data = {f_ctl, f_col, f_pix};

	ipd_cmd_queue #(
		.DATA_W (CMD_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_push),
		.wr_ready (f_space),
		.wr_data  (q_wr_data),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (q_rd_data)
	);

	assign {b_ctl, b_col, b_pix} = q_rd_data;

	ipd_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd_ctl   (b_ctl),
		.cmd_col   (b_col),
		.cmd_pix   (b_pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire

[hdl/ipd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipd_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8,
	localparam int COL_W     = $clog2(MAX_WIDTH),
	localparam int WCNT_W    = $clog2(MAX_WIDTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ipd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ipd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire ipd_pkg::req_t                     req_data,
	output logic                                   cmd_push,
	input  wire logic                              cmd_space,
	output ipd_pkg::cmd_ctl_t                      cmd_ctl,
	output logic [COL_W-1:0]                       cmd_col,
	output logic [PIXEL_BITS-1:0]                  cmd_pix
);

	logic [ipd_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [ipd_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [COL_W-1:0]                 col_q;
	logic [ipd_pkg::ROW_W-1:0]        row_q;
	logic [WCNT_W-1:0]                pend_q;

	logic [WCNT_W-1:0]                wid_eff;
	logic [ipd_pkg::HEIGHT_REG_W-1:0] hgt_eff;
	logic                             accept;
	logic                             is_drain;
	logic                             pend_zero;
	logic                             row_last_col;
	logic                             frame_last_row;
	logic                             drain_last;

	always_comb begin
		if (width_q == '0) begin
			wid_eff = WCNT_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			wid_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			wid_eff = WCNT_W'(width_q);
		end
		if (height_q == '0) begin
			hgt_eff = ipd_pkg::HEIGHT_REG_W'(1);
		end else if (height_q > ipd_pkg::HEIGHT_REG_W'(ipd_pkg::HEIGHT_LIMIT)) begin
			hgt_eff = ipd_pkg::HEIGHT_REG_W'(ipd_pkg::HEIGHT_LIMIT);
		end else begin
			hgt_eff = height_q;
		end
	end

	assign req_ready      = cmd_space;
	assign accept         = req_valid && req_ready;
	assign is_drain       = (req_data.req_type == ipd_pkg::REQ_DRAIN);
	assign pend_zero      = (pend_q == '0);
	assign row_last_col   = (WCNT_W'(col_q) + WCNT_W'(1)) >= wid_eff;
	assign frame_last_row =
		(ipd_pkg::HEIGHT_REG_W'(row_q) + ipd_pkg::HEIGHT_REG_W'(1)) >= hgt_eff;
	assign drain_last     = (pend_q == WCNT_W'(1));

	// drop pixels while draining, and drain ticks with nothing pending
	assign cmd_push = accept && (is_drain ? !pend_zero : pend_zero);

	always_comb begin
		if (is_drain) begin
			cmd_ctl.kind = ipd_pkg::CMD_DRAIN;
		end else if (row_q == '0) begin
			cmd_ctl.kind = ipd_pkg::CMD_ROW0;
		end else begin
			cmd_ctl.kind = ipd_pkg::CMD_PIXEL;
		end
		cmd_ctl.first     = (col_q == '0);
		cmd_ctl.last      = is_drain ? drain_last : row_last_col;
		cmd_ctl.frame_end = is_drain && drain_last;
	end

	assign cmd_col = col_q;
	assign cmd_pix = PIXEL_BITS'(req_data.pixel_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ipd_pkg::WIDTH_RESET;
			height_q <= ipd_pkg::HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			pend_q   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ipd_pkg::CFG_FRAME_WIDTH) begin
					width_q <= cfg_data[ipd_pkg::WIDTH_REG_W-1:0];
				end else if (cfg_index == ipd_pkg::CFG_FRAME_HEIGHT) begin
					height_q <= cfg_data[ipd_pkg::HEIGHT_REG_W-1:0];
				end
			end
			if (cmd_push) begin
				if (is_drain) begin
					pend_q <= pend_q - WCNT_W'(1);
					col_q  <= drain_last ? '0 : col_q + COL_W'(1);
				end else if (row_last_col) begin
					col_q <= '0;
					// last row done: arm the drain for one row of output
					if (frame_last_row) begin
						row_q  <= '0;
						pend_q <= wid_eff;
					end else begin
						row_q <= row_q + ipd_pkg::ROW_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

[hdl/ipd_cmd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipd_cmd_queue #(
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic                   rd_valid,
	input  wire logic              rd_ready,
	output logic [DATA_W-1:0]      rd_data
);

	localparam int DEPTH = ipd_pkg::CMD_Q_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_wr;
	logic              do_rd;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_ready = (cnt_q != CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = slot_q[rp_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= ptr_inc(wp_q);
			end
			if (do_rd) begin
				rp_q <= ptr_inc(rp_q);
			end
			cnt_q <= cnt_q + CNT_W'(do_wr) - CNT_W'(do_rd);
		end
	end

endmodule

`default_nettype wire

[hdl/ipd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipd_back #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8,
	localparam int COL_W     = $clog2(MAX_WIDTH)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cmd_valid,
	output logic                         cmd_ready,
	input  wire ipd_pkg::cmd_ctl_t       cmd_ctl,
	input  wire logic [COL_W-1:0]        cmd_col,
	input  wire logic [PIXEL_BITS-1:0]   cmd_pix,
	output logic                         res_valid,
	input  wire logic                    res_ready,
	output ipd_pkg::res_t                res_data
);

	localparam int ENT_W    = 2 * PIXEL_BITS;
	localparam int OUT_W    = ipd_pkg::PIX_W;
	localparam int TAPS     = ipd_pkg::WIN_TAPS;
	localparam int DIM      = ipd_pkg::WIN_DIM;
	localparam int OQ_DEPTH = ipd_pkg::OUT_Q_DEPTH;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef logic [PIXEL_BITS-1:0] pix_t;
	// taps row-major: rows above/middle/below, columns left/center/right
	typedef logic [TAPS-1:0][PIXEL_BITS-1:0] win_t;

	function automatic pix_t decide(input win_t w);
		logic same;
		same = 1'b1;
		for (int i = 1; i < TAPS; i++) begin
			if (i != ipd_pkg::WIN_CENTER && w[i] != w[0]) begin
				same = 1'b0;
			end
		end
		return same ? w[0] : w[ipd_pkg::WIN_CENTER];
	endfunction

	function automatic win_t shift_in(input win_t w, input pix_t va, input pix_t vm,
			input pix_t vb, input logic first);
		win_t                            n;
		logic [DIM-1:0][PIXEL_BITS-1:0] v;
		v = {vb, vm, va};
		n = w;
		for (int r = 0; r < DIM; r++) begin
			if (first) begin
				n[r*DIM]     = v[r];
				n[r*DIM + 1] = v[r];
			end else begin
				n[r*DIM]     = w[r*DIM + 1];
				n[r*DIM + 1] = w[r*DIM + 2];
			end
			n[r*DIM + 2] = v[r];
		end
		return n;
	endfunction

	function automatic win_t repeat_right(input win_t w);
		win_t n;
		n = w;
		for (int r = 0; r < DIM; r++) begin
			n[r*DIM]     = w[r*DIM + 1];
			n[r*DIM + 1] = w[r*DIM + 2];
		end
		return n;
	endfunction

	function automatic logic [OQ_PTR_W-1:0] oq_inc(input logic [OQ_PTR_W-1:0] p);
		return (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + OQ_PTR_W'(1);
	endfunction

	// line buffer: upper half is the row above, lower half the middle row
	logic [ENT_W-1:0]    line_mem [MAX_WIDTH];
	logic [ENT_W-1:0]    rd_q;
	logic [ENT_W-1:0]    fwd_data_q;
	logic                fwd_q;

	logic                valid_s1;
	ipd_pkg::cmd_ctl_t   ctl_s1;
	logic [COL_W-1:0]    col_s1;
	pix_t                pix_s1;

	win_t                win_q;
	ipd_pkg::res_t       oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wp_q;
	logic [OQ_PTR_W-1:0] oq_rp_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;

	logic                s1_fire;
	logic                pop;
	logic [ENT_W-1:0]    ent;
	pix_t                above;
	pix_t                middle;
	pix_t                below;
	win_t                win_sh;
	win_t                win_rep;
	win_t                tail_win;
	pix_t                res0;
	pix_t                res1;
	logic                do_col;
	logic                mem_we;
	logic [ENT_W-1:0]    wdata;
	logic                push0;
	logic                push1;
	logic                out_pop;
	ipd_pkg::res_t       e0;
	ipd_pkg::res_t       e1;

	// advance only with room for both results of a row end
	assign s1_fire   = valid_s1 && (oq_cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign cmd_ready = !valid_s1 || s1_fire;
	assign pop       = cmd_valid && cmd_ready;

	assign ent    = fwd_q ? fwd_data_q : rd_q;
	assign above  = ent[ENT_W-1:PIXEL_BITS];
	assign middle = ent[PIXEL_BITS-1:0];

	always_comb begin
		unique case (ctl_s1.kind)
			ipd_pkg::CMD_ROW0: begin
				do_col = 1'b0;
				mem_we = s1_fire;
				wdata  = {pix_s1, pix_s1};
				below  = pix_s1;
			end
			ipd_pkg::CMD_PIXEL: begin
				do_col = 1'b1;
				mem_we = s1_fire;
				wdata  = {middle, pix_s1};
				below  = pix_s1;
			end
			ipd_pkg::CMD_DRAIN: begin
				// replicate the last row below itself
				do_col = 1'b1;
				mem_we = 1'b0;
				wdata  = {middle, pix_s1};
				below  = middle;
			end
			default: begin
				do_col = 1'b0;
				mem_we = 1'b0;
				wdata  = {middle, pix_s1};
				below  = pix_s1;
			end
		endcase
	end

	assign win_sh   = shift_in(win_q, above, middle, below, ctl_s1.first);
	assign win_rep  = repeat_right(win_sh);
	assign tail_win = ctl_s1.first ? win_sh : win_rep;
	assign res0     = decide(win_sh);
	assign res1     = decide(tail_win);

	assign push0   = s1_fire && do_col && !ctl_s1.first;
	assign push1   = s1_fire && do_col && ctl_s1.last;
	assign out_pop = res_valid && res_ready;

	always_comb begin
		e0.out_pixel = OUT_W'(res0);
		e0.frame_end = 1'b0;
		e1.out_pixel = OUT_W'(res1);
		e1.frame_end = ctl_s1.frame_end;
	end

	assign res_valid = (oq_cnt_q != '0);
	assign res_data  = oq_q[oq_rp_q];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[col_s1] <= wdata;
		end
		if (pop) begin
			rd_q       <= line_mem[cmd_col];
			// the entry written this cycle is not yet visible to the read
			fwd_q      <= mem_we && (col_s1 == cmd_col);
			fwd_data_q <= wdata;
			ctl_s1     <= cmd_ctl;
			col_s1     <= cmd_col;
			pix_s1     <= cmd_pix;
		end
		if (push0) begin
			oq_q[oq_wp_q] <= e0;
		end
		if (push1) begin
			oq_q[push0 ? oq_inc(oq_wp_q) : oq_wp_q] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			win_q    <= '0;
			oq_wp_q  <= '0;
			oq_rp_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (cmd_ready) begin
				valid_s1 <= cmd_valid;
			end
			if (s1_fire && do_col) begin
				win_q <= (ctl_s1.last && !ctl_s1.first) ? win_rep : win_sh;
			end
			if (push0 && push1) begin
				oq_wp_q <= oq_inc(oq_inc(oq_wp_q));
			end else if (push0 || push1) begin
				oq_wp_q <= oq_inc(oq_wp_q);
			end
			if (out_pop) begin
				oq_rp_q <= oq_inc(oq_rp_q);
			end
			oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(push0) + OQ_CNT_W'(push1)
				- OQ_CNT_W'(out_pop);
		end
	end

endmodule

`default_nettype wire
